// ===== rtl/core/crank_wheel_36_2_2_2_decoder_unit_macros.svh =====
// Assertion macros for the crank wheel decoder checker.
// No dependencies; included by the checker file.
`ifndef CRANK_WHEEL_36_2_2_2_DECODER_UNIT_MACROS_SVH
`define CRANK_WHEEL_36_2_2_2_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwd assertion failed");

// Next-cycle implication that is checked through reset as well.
`define CWD_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cwd reset assertion failed");

`endif

// ===== rtl/core/cwd_pkg.sv =====
// Shared types and constants for the crank wheel decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cwd_pkg;

  localparam int TOOTH_W      = 6;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int WHEEL_TEETH_DEF = 36;

  localparam logic [TOOTH_W-1:0] H4_AFTER_DOUBLE = 6'd19;
  localparam logic [TOOTH_W-1:0] H6_AFTER_DOUBLE = 6'd12;
  localparam logic [TOOTH_W-1:0] H4_AFTER_SINGLE = 6'd35;
  localparam logic [TOOTH_W-1:0] H6_AFTER_SINGLE = 6'd34;
  localparam logic [TOOTH_W-1:0] TOOTH_ONE       = 6'd1;
  localparam logic [TOOTH_W-1:0] MISSING_STEP    = 6'd2;

  localparam logic [CFG_W-1:0]   FILTER_RESET    = 16'd92;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_VARIANT  = 2'd0,
    CFG_INITIAL_FILTER = 2'd1,
    CFG_FILTER_LEVEL   = 2'd2
  } cwd_cfg_idx_t;

  typedef enum logic [1:0] {
    VAR_H4    = 2'd0,
    VAR_H6    = 2'd1,
    VAR_OTHER = 2'd2
  } cwd_variant_t;

  typedef enum logic [1:0] {
    LVL_NONE    = 2'd0,
    LVL_QUARTER = 2'd1,
    LVL_HALF    = 2'd2,
    LVL_3QUART  = 2'd3
  } cwd_level_t;

  typedef struct packed {
    logic [1:0]       wheel_variant;
    logic [1:0]       filter_level;
    logic             filter_load;
    logic [CFG_W-1:0] filter_value;
  } cwd_cfg_t;

  typedef struct packed {
    logic               accepted;
    logic [TOOTH_W-1:0] tooth_number;
    logic               in_sync;
    logic               angle_regular;
    logic               revolution_odd;
    logic               new_revolution;
  } cwd_result_t;

endpackage

// ===== rtl/core/cwd_cfg_regs.sv =====
// Configuration registers of the crank wheel decoder.
// Depends on cwd_pkg.
`timescale 1ns / 1ps

module cwd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwd_pkg::CFG_W-1:0]   cfg_wdata,
  output cwd_pkg::cwd_cfg_t           cfg
);
  import cwd_pkg::*;

  logic [1:0] variant_r, variant_nxt;
  logic [1:0] level_r, level_nxt;
  logic       load;

  always_comb begin
    variant_nxt = variant_r;
    level_nxt   = level_r;
    load        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_VARIANT:  variant_nxt = cfg_wdata[1:0];
        CFG_INITIAL_FILTER: load        = 1'b1;
        CFG_FILTER_LEVEL:   level_nxt   = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VAR_H4;
      level_r   <= LVL_QUARTER;
    end else begin
      variant_r <= variant_nxt;
      level_r   <= level_nxt;
    end
  end

  assign cfg.wheel_variant = variant_r;
  assign cfg.filter_level  = level_r;
  assign cfg.filter_load   = load;
  assign cfg.filter_value  = cfg_wdata;

endmodule

// ===== rtl/core/cwd_in_reg.sv =====
// Input register of the crank wheel decoder: holds one edge item.
// Depends on cwd_pkg.
`timescale 1ns / 1ps

module cwd_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cwd_pkg::TIME_W-1:0] in_edge_time,
  input  logic                       advance,
  output logic                       item_valid,
  output logic [cwd_pkg::TIME_W-1:0] item_time
);
  import cwd_pkg::*;

  logic              valid_r;
  logic [TIME_W-1:0] time_r;

  // The slot frees up in the same cycle its item moves on.
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      time_r <= in_edge_time;
    end
  end

  assign item_valid = valid_r;
  assign item_time  = time_r;

endmodule

// ===== rtl/core/cwd_track.sv =====
// Tooth tracking state and the per-edge update: filter, gap test, count, sync.
// Depends on cwd_pkg.
`timescale 1ns / 1ps

module cwd_track #(
  parameter int WHEEL_TEETH = cwd_pkg::WHEEL_TEETH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cwd_pkg::cwd_cfg_t          cfg,
  input  logic                       step_en,
  input  logic [cwd_pkg::TIME_W-1:0] edge_time,
  output cwd_pkg::cwd_result_t       result
);
  import cwd_pkg::*;

  localparam logic [TOOTH_W-1:0] TEETH = TOOTH_W'(WHEEL_TEETH);

  logic [TIME_W-1:0]  last_r, prior_r, target_r, filter_r;
  logic [TIME_W-1:0]  last_nxt, prior_nxt, target_nxt, filter_nxt;
  logic               phase_r, sync_r, regular_r, rev_r;
  logic               phase_nxt, sync_nxt, regular_nxt, rev_nxt;
  logic [TOOTH_W-1:0] count_r, count_nxt;

  logic [TIME_W-1:0]  gap, gap_eff, target_use, filt_gap;
  logic [TIME_W+1:0]  gap3;
  logic [TOOTH_W-1:0] count_inc;
  logic               pass, new_rev;

  assign gap        = edge_time - last_r;
  assign pass       = (gap >= filter_r);
  assign count_inc  = count_r + TOOTH_ONE;
  assign target_use = phase_r ? target_r : ((last_r - prior_r) << 1);
  // Until both the last and the prior edge time have been recorded the period is unknown.
  assign gap_eff    = ((last_r == '0) || (prior_r == '0)) ? '0 : gap;
  assign gap3       = {2'b00, gap_eff} + {1'b0, gap_eff, 1'b0};

  always_comb begin
    case (cfg.filter_level)
      LVL_QUARTER: filt_gap = gap_eff >> 2;
      LVL_HALF:    filt_gap = gap_eff >> 1;
      LVL_3QUART:  filt_gap = gap3[TIME_W+1:2];
      default:     filt_gap = '0;
    endcase
  end

  always_comb begin
    last_nxt    = last_r;
    prior_nxt   = prior_r;
    target_nxt  = target_r;
    filter_nxt  = filter_r;
    phase_nxt   = phase_r;
    sync_nxt    = sync_r;
    regular_nxt = regular_r;
    rev_nxt     = rev_r;
    count_nxt   = count_r;
    new_rev     = 1'b0;
    if (pass) begin
      target_nxt = target_use;
      prior_nxt  = last_r;
      last_nxt   = edge_time;
      count_nxt  = count_inc;
      if (gap_eff > target_use) begin
        // Missing-tooth gap: the second one in a row identifies the wheel.
        if (phase_r) begin
          if (cfg.wheel_variant == VAR_H4) begin
            count_nxt = H4_AFTER_DOUBLE;
          end else if (cfg.wheel_variant == VAR_H6) begin
            count_nxt = H6_AFTER_DOUBLE;
          end
          phase_nxt = 1'b0;
          sync_nxt  = 1'b1;
        end else begin
          phase_nxt = 1'b1;
          count_nxt = count_inc + MISSING_STEP;
        end
        regular_nxt = 1'b0;
        filter_nxt  = '0;
      end else begin
        if (count_inc > TEETH) begin
          count_nxt = TOOTH_ONE;
          rev_nxt   = !rev_r;
          new_rev   = 1'b1;
        end else if (phase_r) begin
          // Regular tooth right after a lone missing gap.
          if (cfg.wheel_variant == VAR_H4) begin
            count_nxt = H4_AFTER_SINGLE;
            sync_nxt  = 1'b1;
          end else if (cfg.wheel_variant == VAR_H6) begin
            count_nxt = H6_AFTER_SINGLE;
            sync_nxt  = 1'b1;
          end
        end
        filter_nxt  = filt_gap;
        regular_nxt = 1'b1;
        phase_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      prior_r   <= '0;
      target_r  <= '0;
      filter_r  <= {{(TIME_W-CFG_W){1'b0}}, FILTER_RESET};
      phase_r   <= 1'b0;
      sync_r    <= 1'b0;
      regular_r <= 1'b0;
      rev_r     <= 1'b0;
      count_r   <= '0;
    end else begin
      if (step_en) begin
        last_r    <= last_nxt;
        prior_r   <= prior_nxt;
        target_r  <= target_nxt;
        phase_r   <= phase_nxt;
        sync_r    <= sync_nxt;
        regular_r <= regular_nxt;
        rev_r     <= rev_nxt;
        count_r   <= count_nxt;
      end
      if (cfg.filter_load) begin
        filter_r <= {{(TIME_W-CFG_W){1'b0}}, cfg.filter_value};
      end else if (step_en) begin
        filter_r <= filter_nxt;
      end
    end
  end

  assign result.accepted       = pass;
  assign result.tooth_number   = count_nxt;
  assign result.in_sync        = sync_nxt;
  assign result.angle_regular  = regular_nxt;
  assign result.revolution_odd = rev_nxt;
  assign result.new_revolution = new_rev;

endmodule

// ===== rtl/core/crank_wheel_36_2_2_2_decoder_unit.sv =====
// Top level of the 36-2-2-2 crank wheel decoder: input register, tracker,
// result register. Depends on cwd_pkg, cwd_cfg_regs, cwd_in_reg, cwd_track.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_edge_time
//   out_     output     out_valid / out_ready   accepted, tooth_number, flags
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// One edge item per cycle while the result is not stalled. An item is held in the
// input register, then its result sits in the result register until it is taken.
// The tracker state updates as an item moves from input to result register.
// Reset (rst_n low, synchronous) empties both registers and clears the state.
// A stalled result holds the input register; once that register is full, in_ready drops.
`timescale 1ns / 1ps

module crank_wheel_36_2_2_2_decoder_unit #(
  parameter int WHEEL_TEETH = cwd_pkg::WHEEL_TEETH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cwd_pkg::TIME_W-1:0]    in_edge_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [cwd_pkg::TOOTH_W-1:0]   out_tooth_number,
  output logic                          out_in_sync,
  output logic                          out_angle_regular,
  output logic                          out_revolution_odd,
  output logic                          out_new_revolution,
  input  logic                          cfg_we,
  input  logic [cwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwd_pkg::CFG_W-1:0]     cfg_wdata
);
  import cwd_pkg::*;

  cwd_cfg_t          cfg;
  cwd_result_t       step_res, res_r;
  logic              item_valid, advance, out_valid_r;
  logic [TIME_W-1:0] item_time;

  assign advance = item_valid && (!out_valid_r || out_ready);

  cwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cwd_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_edge_time (in_edge_time),
    .advance      (advance),
    .item_valid   (item_valid),
    .item_time    (item_time)
  );

  cwd_track #(
    .WHEEL_TEETH (WHEEL_TEETH)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (advance),
    .edge_time (item_time),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = res_r.accepted;
  assign out_tooth_number   = res_r.tooth_number;
  assign out_in_sync        = res_r.in_sync;
  assign out_angle_regular  = res_r.angle_regular;
  assign out_revolution_odd = res_r.revolution_odd;
  assign out_new_revolution = res_r.new_revolution;

endmodule

// ===== rtl/core/cwd_checker.sv =====
// Port-level checker for the crank wheel decoder, bound to the top level.
// Depends on cwd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "crank_wheel_36_2_2_2_decoder_unit_macros.svh"

module cwd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_accepted,
  input logic [cwd_pkg::TOOTH_W-1:0] out_tooth_number,
  input logic                        out_in_sync,
  input logic                        out_angle_regular,
  input logic                        out_revolution_odd,
  input logic                        out_new_revolution
);
  import cwd_pkg::*;

  // A waiting result holds every field until it is taken.
  `CWD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_accepted) && $stable(out_tooth_number) && $stable(out_in_sync) && $stable(out_angle_regular) && $stable(out_revolution_odd) && $stable(out_new_revolution))

  // A wrap always lands on tooth one, on an accepted regular tooth.
  `CWD_ASSERT_IMP(a_wrap, clk, rst_n, out_valid && out_new_revolution, out_accepted && out_angle_regular && (out_tooth_number == TOOTH_ONE))

  // With the result register empty the input side never stalls.
  `CWD_ASSERT_IMP(a_no_stall, clk, rst_n, !out_valid, in_ready)

  // After an item is taken, a result is waiting on the output.
  `CWD_ASSERT_NXT(a_latency, clk, rst_n, in_valid && in_ready, ##1 out_valid)

  // Reset empties the result register.
  `CWD_ASSERT_RST(a_reset, clk, !rst_n, !out_valid)

endmodule

bind crank_wheel_36_2_2_2_decoder_unit cwd_checker u_cwd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_accepted       (out_accepted),
  .out_tooth_number   (out_tooth_number),
  .out_in_sync        (out_in_sync),
  .out_angle_regular  (out_angle_regular),
  .out_revolution_odd (out_revolution_odd),
  .out_new_revolution (out_new_revolution)
);
